@@ hdl/xalu_pkg.sv @@
// Package for the x86-style integer ALU: command codes, size codes and
// the control/status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps
package xalu_pkg;

    localparam logic [3:0] CMD_ADD  = 4'd0;
    localparam logic [3:0] CMD_ADC  = 4'd1;
    localparam logic [3:0] CMD_SUB  = 4'd2;
    localparam logic [3:0] CMD_SBB  = 4'd3;
    localparam logic [3:0] CMD_AND  = 4'd4;
    localparam logic [3:0] CMD_OR   = 4'd5;
    localparam logic [3:0] CMD_XOR  = 4'd6;
    localparam logic [3:0] CMD_SHL  = 4'd7;
    localparam logic [3:0] CMD_SHR  = 4'd8;
    localparam logic [3:0] CMD_SAR  = 4'd9;
    localparam logic [3:0] CMD_MUL  = 4'd10;
    localparam logic [3:0] CMD_IMUL = 4'd11;
    localparam logic [3:0] CMD_DIV  = 4'd12;
    localparam logic [3:0] CMD_IDIV = 4'd13;
    localparam logic [3:0] CMD_MOD  = 4'd14;
    localparam logic [3:0] CMD_IMOD = 4'd15;

    localparam logic [1:0] SIZE_8  = 2'd0;
    localparam logic [1:0] SIZE_16 = 2'd1;
    localparam logic [1:0] SIZE_32 = 2'd2;

    localparam int DIV_STEPS = 64;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // capture a new request and start it
        logic div_step;   // run one restoring-division step
        logic finish;     // compute the result and update flags
    } xalu_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_div;     // loaded request is a divide or modulo
        logic div_last;   // the current division step is the last one
    } xalu_stat_t;

endpackage

@@ hdl/xalu_datapath.sv @@
// Datapath of the x86-style ALU: operand registers, flag registers,
// combinational arithmetic and a bit-serial 64-bit divider. Uses xalu_pkg.
`timescale 1ns / 1ps
module xalu_datapath
    import xalu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  xalu_cmd_t   cmd,
    output xalu_stat_t  stat,
    input  logic [3:0]  command,
    input  logic [63:0] source_operand,
    input  logic [63:0] dest_operand,
    input  logic [1:0]  size_code,
    output logic [63:0] result_value,
    output logic        carry_out,
    output logic        parity_out,
    output logic        zero_out,
    output logic        sign_out,
    output logic        overflow_out
);

    logic [3:0]  op_reg;
    logic [63:0] src_reg;
    logic [63:0] dst_reg;
    logic [1:0]  size_reg;
    logic [63:0] quo_reg, quo_next;
    logic [63:0] rem_reg, rem_next;
    logic [5:0]  step_reg;
    logic        neg_q_reg, neg_r_reg;
    logic        cf_reg, pf_reg, zf_reg, sf_reg, of_reg;
    logic        cf_next, pf_next, zf_next, sf_next, of_next;
    logic [63:0] res_next;

    // Division operands: magnitudes for signed commands.
    logic        is_signed_div;
    logic [63:0] dvd_abs, dvs_abs;
    logic [63:0] dvs_reg;

    assign is_signed_div = (command == CMD_IDIV) || (command == CMD_IMOD);
    assign dvd_abs = (is_signed_div && dest_operand[63]) ? -dest_operand : dest_operand;
    assign dvs_abs = (is_signed_div && source_operand[63]) ? -source_operand
                                                           : source_operand;

    assign stat.is_div   = op_reg[3] && op_reg[2];
    assign stat.div_last = (step_reg == 6'(DIV_STEPS - 1));

    // One restoring-division step: shift in the next dividend bit.
    logic [64:0] trial_rem;
    logic [64:0] diff;
    assign trial_rem = {rem_reg, quo_reg[63]};
    assign diff      = trial_rem - {1'b0, dvs_reg};
    always_comb
    begin
        if (!diff[64])
        begin
            rem_next = diff[63:0];
            quo_next = {quo_reg[62:0], 1'b1};
        end
        else
        begin
            rem_next = trial_rem[63:0];
            quo_next = {quo_reg[62:0], 1'b0};
        end
    end

    // Signed quotient and remainder after the last step.
    logic [63:0] quo_fix, rem_fix;
    assign quo_fix = neg_q_reg ? -quo_reg : quo_reg;
    assign rem_fix = neg_r_reg ? -rem_reg : rem_reg;

    // Operand width decode and masking.
    logic [5:0]  w;
    logic [31:0] m;
    logic [31:0] s, d;
    always_comb
    begin
        unique case (size_reg)
            SIZE_8:  begin w = 6'd8;  m = 32'h0000_00FF; end
            SIZE_16: begin w = 6'd16; m = 32'h0000_FFFF; end
            default: begin w = 6'd32; m = 32'hFFFF_FFFF; end
        endcase
        s = src_reg[31:0] & m;
        d = dst_reg[31:0] & m;
    end

    logic [4:0]  wm1;
    logic [5:0]  cnt;
    logic        sbit_d;
    logic [31:0] sx_s, sx_d;
    assign wm1    = 5'(w - 6'd1);
    assign sbit_d = d[wm1];
    assign cnt    = (src_reg[31:0] > {26'd0, w} + 32'd1) ? (w + 6'd1) : src_reg[5:0];
    assign sx_s   = s[wm1] ? (s | ~m) : s;
    assign sx_d   = sbit_d ? (d | ~m) : d;

    // Combinational result and flag computation.
    logic [32:0] sum;
    logic [63:0] shl_full, sar_full;
    logic [63:0] mul_u, mul_s;
    logic [31:0] r32;
    logic [31:0] t_sar;
    logic        flags_szp;
    assign mul_u = {32'd0, s} * {32'd0, d};
    assign mul_s = $signed({{32{sx_s[31]}}, sx_s}) * $signed({{32{sx_d[31]}}, sx_d});
    assign t_sar = (op_reg == CMD_SAR && sbit_d) ? (d | ~m) : d;
    always_comb
    begin
        cf_next = cf_reg;
        of_next = of_reg;
        flags_szp = 1'b0;
        r32 = 32'd0;
        res_next = 64'd0;
        sum = 33'd0;
        shl_full = {32'd0, d} << cnt;
        sar_full = {{32{t_sar[31] & (op_reg == CMD_SAR)}}, t_sar} >> cnt;
        unique case (op_reg)
            CMD_ADD, CMD_ADC:
            begin
                sum = {1'b0, s} + {1'b0, d} + {32'd0, (op_reg == CMD_ADC) & cf_reg};
                r32 = sum[31:0] & m;
                cf_next = sum[w];
                of_next = (~(s[wm1] ^ d[wm1])) & (s[wm1] ^ r32[wm1]);
                flags_szp = 1'b1;
            end
            CMD_SUB, CMD_SBB:
            begin
                if (op_reg == CMD_SBB && cf_reg)
                begin
                    r32 = (d - s - 32'd1) & m;
                    cf_next = (d <= s);
                end
                else
                begin
                    r32 = (d - s) & m;
                    cf_next = (d < s);
                end
                of_next = (s[wm1] ^ d[wm1]) & (d[wm1] ^ r32[wm1]);
                flags_szp = 1'b1;
            end
            CMD_AND, CMD_OR, CMD_XOR:
            begin
                r32 = (op_reg == CMD_AND) ? (s & d) : (op_reg == CMD_OR) ? (s | d) : (s ^ d);
                flags_szp = 1'b1;
            end
            CMD_SHL:
            begin
                r32 = shl_full[31:0] & m;
                // The last bit shifted out lands just above the operand width.
                if (cnt != 6'd0)
                begin
                    cf_next = shl_full[w];
                end
                flags_szp = 1'b1;
            end
            CMD_SHR, CMD_SAR:
            begin
                r32 = sar_full[31:0] & m;
                if (cnt != 6'd0)
                begin
                    cf_next = (({{32{t_sar[31] & (op_reg == CMD_SAR)}}, t_sar}
                               >> (cnt - 6'd1)) & 64'd1) != 64'd0;
                end
                flags_szp = 1'b1;
            end
            CMD_MUL:
            begin
                res_next = mul_u;
                cf_next = (mul_u >> w) != 64'd0;
                of_next = cf_next;
            end
            CMD_IMUL:
            begin
                res_next = mul_s;
            end
            CMD_DIV, CMD_IDIV:
            begin
                res_next = (dvs_reg == 64'd0) ? 64'd0 : {32'd0, quo_fix[31:0]};
            end
            default:
            begin
                res_next = (dvs_reg == 64'd0) ? 64'd0 : {32'd0, rem_fix[31:0]};
            end
        endcase
        if (flags_szp)
            res_next = {32'd0, r32};
        pf_next = flags_szp ? ~(^r32[7:0]) : pf_reg;
        zf_next = flags_szp ? (r32 == 32'd0) : zf_reg;
        sf_next = flags_szp ? r32[wm1] : sf_reg;
    end

    // Flag registers and division step counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cf_reg <= 1'b0;
            pf_reg <= 1'b0;
            zf_reg <= 1'b0;
            sf_reg <= 1'b0;
            of_reg <= 1'b0;
            step_reg <= 6'd0;
        end
        else
        begin
            if (cmd.load)
                step_reg <= 6'd0;
            else if (cmd.div_step)
                step_reg <= step_reg + 6'd1;
            if (cmd.finish)
            begin
                cf_reg <= cf_next;
                pf_reg <= pf_next;
                zf_reg <= zf_next;
                sf_reg <= sf_next;
                of_reg <= of_next;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= command;
            src_reg   <= source_operand;
            dst_reg   <= dest_operand;
            size_reg  <= size_code;
            quo_reg   <= dvd_abs;
            dvs_reg   <= dvs_abs;
            rem_reg   <= 64'd0;
            neg_q_reg <= is_signed_div && (dest_operand[63] ^ source_operand[63]);
            neg_r_reg <= is_signed_div && dest_operand[63];
        end
        else if (cmd.div_step)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
        if (cmd.finish)
            result_value <= res_next;
    end

    assign carry_out    = cf_reg;
    assign parity_out   = pf_reg;
    assign zero_out     = zf_reg;
    assign sign_out     = sf_reg;
    assign overflow_out = of_reg;

`ifndef SYNTHESIS
    // Division steps never run past the last dividend bit.
    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step && stat.div_last |=> step_reg == 6'd0 || !cmd.div_step)
        else $error("division step counter ran past the end");
    // Logic operations leave CF and OF unchanged.
    a_logic_keep: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish && (op_reg == CMD_AND || op_reg == CMD_OR || op_reg == CMD_XOR)
        |=> $stable(cf_reg) && $stable(of_reg))
        else $error("logic operation changed CF or OF");
    // Commands are exclusive.
    a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.div_step, cmd.finish}))
        else $error("controller issued overlapping commands");
`endif

endmodule

@@ hdl/xalu_ctrl.sv @@
// Controller of the x86-style ALU: sequences load, division steps and
// finish, and runs the request handshakes. Uses xalu_pkg.
`timescale 1ns / 1ps
module xalu_ctrl
    import xalu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  xalu_stat_t stat,
    output xalu_cmd_t  cmd
);

    typedef enum logic [1:0] {S_IDLE, S_DECODE, S_DIVIDE, S_FINISH} state_t;
    state_t state_reg;
    logic   out_valid_reg;

    // The output register frees up when taken, so a new request may enter.
    assign in_ready  = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd.load     = in_valid && in_ready;
        cmd.div_step = (state_reg == S_DIVIDE);
        cmd.finish   = (state_reg == S_FINISH);
    end

    // State and output-valid register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                    if (cmd.load)
                        state_reg <= S_DECODE;
                S_DECODE:
                    state_reg <= stat.is_div ? S_DIVIDE : S_FINISH;
                S_DIVIDE:
                    if (stat.div_last)
                        state_reg <= S_FINISH;
                S_FINISH:
                begin
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    // A result is never overwritten while it waits.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> !out_valid_reg)
        else $error("finish over pending result");
    // A request is only taken in idle.
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> state_reg == S_DECODE)
        else $error("load outside idle");
    // Finish raises valid next cycle.
    a_finish_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> out_valid_reg)
        else $error("finished result not presented");
`endif

endmodule

@@ hdl/x86_integer_alu_with_flags.sv @@
// x86-style integer ALU with CF/PF/ZF/SF/OF flags, top level.
// A request passes through the decode and finish states before its result is
// presented; div/idiv/mod/imod also run 64 divider steps in between.
// A new request is accepted only in idle, once the output register is free.
// Reset (rst_n, asynchronous, active low) clears all flags and the handshake.
`timescale 1ns / 1ps
module x86_integer_alu_with_flags
    import xalu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [3:0]  command,
    input  logic [63:0] source_operand,
    input  logic [63:0] dest_operand,
    input  logic [1:0]  size_code,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] result_value,
    output logic        carry_out,
    output logic        parity_out,
    output logic        zero_out,
    output logic        sign_out,
    output logic        overflow_out
);

    xalu_cmd_t  cmd;
    xalu_stat_t stat;

    // Sequencer.
    xalu_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Arithmetic and flag state.
    xalu_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .command        (command),
        .source_operand (source_operand),
        .dest_operand   (dest_operand),
        .size_code      (size_code),
        .result_value   (result_value),
        .carry_out      (carry_out),
        .parity_out     (parity_out),
        .zero_out       (zero_out),
        .sign_out       (sign_out),
        .overflow_out   (overflow_out)
    );

endmodule

@@ tb/sv/tb.sv @@
// Self-checking testbench for the x86-style integer ALU with flags.
// Depends on xalu_pkg and the x86_integer_alu_with_flags top level only.
`timescale 1ns / 1ps
module tb
    import xalu_pkg::*;
();

    typedef struct {
        logic [63:0] value;
        logic        cf, pf, zf, sf, of;
    } alu_result_t;

    // Flag-tracking ALU predictor and the queue of pending results.
    class alu_scoreboard;
        logic        cf, pf, zf, sf, of;
        alu_result_t pending[$];
        int          errors;
        int          checked;

        function void clear_flags();
            cf = 0; pf = 0; zf = 0; sf = 0; of = 0;
        endfunction

        function void set_szp(logic [63:0] r, int w);
            logic [63:0] m;
            m = (64'd1 << w) - 1;
            pf = ~^r[7:0];
            zf = ((r & m) == 0);
            sf = r[w-1];
        endfunction

        function logic [63:0] sdiv(logic [63:0] a, logic [63:0] b, bit want_rem);
            logic [63:0] ua, ub, q, r;
            ua = a[63] ? -a : a;
            ub = b[63] ? -b : b;
            if (ub == 0) return 0;
            q = ua / ub;
            r = ua % ub;
            if (want_rem) return a[63] ? -r : r;
            return (a[63] != b[63]) ? -q : q;
        endfunction

        // Computes the result of one accepted request and queues it.
        function void note_request(logic [3:0] cmd, logic [63:0] src, logic [63:0] dst,
                                   logic [1:0] sz);
            int          w;
            logic [63:0] m, s, d, cnt, sb, res, t;
            alu_result_t e;
            w = (sz == SIZE_8) ? 8 : (sz == SIZE_16) ? 16 : 32;
            m = (64'd1 << w) - 1;
            s = src & m;
            d = dst & m;
            cnt = src & 64'hFFFF_FFFF;
            sb = 64'd1 << (w - 1);
            res = 0;
            if (cnt > w + 1) cnt = w + 1;
            case (cmd)
                CMD_ADD, CMD_ADC:
                begin
                    t = s + d + ((cmd == CMD_ADC) ? cf : 1'b0);
                    res = t & m;
                    cf = t[w];
                    of = (((~(s ^ d)) & (s ^ res)) >> (w - 1)) & 1;
                    set_szp(res, w);
                end
                CMD_SUB, CMD_SBB:
                begin
                    if (cmd == CMD_SBB && cf)
                    begin
                        res = (d - s - 1) & m;
                        cf = (d <= s);
                    end
                    else
                    begin
                        res = (d - s) & m;
                        cf = (d < s);
                    end
                    of = (((s ^ d) & (d ^ res)) >> (w - 1)) & 1;
                    set_szp(res, w);
                end
                CMD_AND, CMD_OR, CMD_XOR:
                begin
                    res = (cmd == CMD_AND) ? (s & d) : (cmd == CMD_OR) ? (s | d) : (s ^ d);
                    set_szp(res, w);
                end
                CMD_SHL:
                begin
                    res = (d << cnt) & m;
                    if (cnt != 0) cf = ((d << (cnt - 1)) >> (w - 1)) & 1;
                    set_szp(res, w);
                end
                CMD_SHR, CMD_SAR:
                begin
                    t = d;
                    if (cmd == CMD_SAR && (d & sb) != 0) t = d | ~m;
                    res = (t >> cnt) & m;
                    if (cnt != 0) cf = (t >> (cnt - 1)) & 1;
                    set_szp(res, w);
                end
                CMD_MUL:
                begin
                    res = s * d;
                    cf = ((res >> w) != 0);
                    of = cf;
                end
                CMD_IMUL:
                begin
                    if (s & sb) s = s | ~m;
                    if (d & sb) d = d | ~m;
                    res = s * d;
                end
                CMD_DIV:  res = (src == 0) ? 0 : (dst / src) & 64'hFFFF_FFFF;
                CMD_IDIV: res = sdiv(dst, src, 0) & 64'hFFFF_FFFF;
                CMD_MOD:  res = (src == 0) ? 0 : (dst % src) & 64'hFFFF_FFFF;
                default:  res = sdiv(dst, src, 1) & 64'hFFFF_FFFF;
            endcase
            e.value = res;
            e.cf = cf; e.pf = pf; e.zf = zf; e.sf = sf; e.of = of;
            pending.push_back(e);
        endfunction

        function void check_result(alu_result_t a);
            alu_result_t e;
            if (pending.size() == 0)
            begin
                $error("result 0x%h arrived with no request outstanding", a.value);
                errors++;
                return;
            end
            e = pending.pop_front();
            checked++;
            if (a.value !== e.value)
            begin
                $error("result_value: expected 0x%h, got 0x%h", e.value, a.value);
                errors++;
            end
            if (a.cf !== e.cf)
            begin
                $error("carry_out: expected %b, got %b", e.cf, a.cf);
                errors++;
            end
            if (a.pf !== e.pf)
            begin
                $error("parity_out: expected %b, got %b", e.pf, a.pf);
                errors++;
            end
            if (a.zf !== e.zf)
            begin
                $error("zero_out: expected %b, got %b", e.zf, a.zf);
                errors++;
            end
            if (a.sf !== e.sf)
            begin
                $error("sign_out: expected %b, got %b", e.sf, a.sf);
                errors++;
            end
            if (a.of !== e.of)
            begin
                $error("overflow_out: expected %b, got %b", e.of, a.of);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [3:0]  command;
    logic [63:0] source_operand;
    logic [63:0] dest_operand;
    logic [1:0]  size_code;
    logic        out_valid;
    logic        out_ready;
    logic [63:0] result_value;
    logic        carry_out, parity_out, zero_out, sign_out, overflow_out;

    x86_integer_alu_with_flags u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .command(command), .source_operand(source_operand),
        .dest_operand(dest_operand), .size_code(size_code),
        .out_valid(out_valid), .out_ready(out_ready),
        .result_value(result_value), .carry_out(carry_out),
        .parity_out(parity_out), .zero_out(zero_out),
        .sign_out(sign_out), .overflow_out(overflow_out)
    );

    alu_scoreboard flag_model;
    int  send_idle_pct;
    int  recv_stall_pct;
    bit  hold_off;
    int  requests_sent;
    int  div_requests;

    // Clock generation.
    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    // Watchdog: the slowest run is well under this.
    initial
    begin
        #(20ns * 1500000);
        $display("TEST FAILED");
        $finish;
    end

    // Sends one request and waits for it to be accepted. Valid stays high
    // into the next request unless the sender idles first.
    task automatic send_request(logic [3:0] cmd, logic [63:0] src, logic [63:0] dst,
                                logic [1:0] sz);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 0;
            @(negedge clk);
        end
        in_valid <= 1;
        command <= cmd;
        source_operand <= src;
        dest_operand <= dst;
        size_code <= sz;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        flag_model.note_request(cmd, src, dst, sz);
        requests_sent++;
        if (cmd >= CMD_DIV) div_requests++;
        @(negedge clk);
    endtask

    function automatic logic [63:0] random_operand();
        case ($urandom_range(5))
            0: return 0;
            1: return {$urandom, $urandom};
            2: return 64'hFFFF_FFFF_FFFF_FFFF;
            3: return 64'($urandom_range(40));
            4: return 64'h8000_0000_0000_0000 | 64'($urandom_range(3));
            default: return {32'd0, $urandom};
        endcase
    endfunction

    task automatic send_random(int n);
        logic [3:0]  cmd;
        logic [63:0] src;
        for (int i = 0; i < n; i++)
        begin
            cmd = 4'($urandom_range(15));
            src = random_operand();
            // Favor shift counts around the operand widths.
            if (cmd >= CMD_SHL && cmd <= CMD_SAR && $urandom_range(1))
                src = 64'($urandom_range(35));
            send_request(cmd, src, random_operand(), 2'($urandom_range(3)));
        end
    endtask

    // Drops valid and waits for every outstanding result; ends at a falling edge.
    task automatic drain();
        in_valid <= 0;
        while (flag_model.pending.size() != 0) @(posedge clk);
        repeat (80) @(posedge clk);
        @(negedge clk);
    endtask

    // Receiver: stalls at random, holds off completely when asked.
    initial
    begin
        out_ready = 0;
        forever
        begin
            @(negedge clk);
            out_ready <= !hold_off &&
                         !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        alu_result_t got;
        if (rst_n && out_valid && out_ready)
        begin
            got.value = result_value;
            got.cf = carry_out; got.pf = parity_out; got.zf = zero_out;
            got.sf = sign_out; got.of = overflow_out;
            flag_model.check_result(got);
        end
    end

    // Long receiver hold-off counted in its own process.
    task automatic hold_off_receiver();
        hold_off = 1;
        repeat (300) @(negedge clk);
        hold_off = 0;
    endtask

    initial
    begin
        logic [63:0] edges[6];
        flag_model = new();
        flag_model.clear_flags();
        flag_model.errors = 0;
        flag_model.checked = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off = 0;
        requests_sent = 0;
        div_requests = 0;
        in_valid = 0;
        command = CMD_ADD;
        source_operand = 0;
        dest_operand = 0;
        size_code = SIZE_8;
        rst_n = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // Directed: every command at edge operands, carries into adc/sbb,
        // shift counts at zero and beyond width, division by zero and wrap.
        edges = '{64'd0, 64'hFF, 64'h80, 64'h7FFF_FFFF, 64'hFFFF_FFFF,
                  64'hFFFF_FFFF_FFFF_FFFF};
        for (int c = 0; c < 16; c++)
            send_request(c[3:0], edges[c % 6], edges[(c + 3) % 6], 2'(c % 4));
        send_request(CMD_ADD, 64'hFF, 64'h1, SIZE_8);
        send_request(CMD_ADC, 64'h0, 64'h0, SIZE_8);
        send_request(CMD_SUB, 64'h1, 64'h0, SIZE_32);
        send_request(CMD_SBB, 64'h0, 64'h0, SIZE_16);
        send_request(CMD_SHL, 64'h0, 64'h81, SIZE_8);
        send_request(CMD_SAR, 64'h1_0000_0040, 64'h8000, SIZE_16);
        send_request(CMD_SHR, 64'd33, 64'hFFFF_FFFF, SIZE_32);
        send_request(CMD_IDIV, 64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000, SIZE_32);
        send_request(CMD_IMOD, 64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000, SIZE_32);
        drain();

        // Random phases with different idling mixes.
        send_random(450);
        send_idle_pct = 54;
        send_random(350);
        send_idle_pct = 0;
        recv_stall_pct = 54;
        send_random(350);
        send_idle_pct = 38;
        recv_stall_pct = 38;
        send_random(300);

        // Receiver holds off while requests keep coming.
        send_idle_pct = 0;
        recv_stall_pct = 0;
        fork
            hold_off_receiver();
            send_random(40);
        join
        send_random(300);
        drain();

        $display("Sent %0d requests (%0d divide/modulo), checked %0d results",
                 requests_sent, div_requests, flag_model.checked);
        $display("under no idling, sender gaps, receiver stalls and a long hold-off.");
        if (flag_model.errors == 0 && flag_model.pending.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

@@ filelist.f @@
hdl/xalu_pkg.sv
hdl/xalu_datapath.sv
hdl/xalu_ctrl.sv
hdl/x86_integer_alu_with_flags.sv
tb/sv/tb.sv
